[rtl/aist_pkg.sv]
// Shared field widths and sequencer state codes for the active/inactive set tracker.
package aist_pkg;

  // Fixed widths of the item and result fields
  localparam int ITEM_W = 10;
  localparam int CNT_W  = 11;

  // Sequencer states
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_INIT = 2'd0;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd1;
  localparam logic [ST_W-1:0] ST_EXEC = 2'd2;

endpackage

[rtl/aist_ram.sv]
// Generic two-port synchronous RAM with registered read data.
module aist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     a_en,
  input  logic                     a_we,
  input  logic [$clog2(DEPTH)-1:0] a_addr,
  input  logic [WIDTH-1:0]         a_wdata,
  output logic [WIDTH-1:0]         a_rdata,
  input  logic                     b_en,
  input  logic                     b_we,
  input  logic [$clog2(DEPTH)-1:0] b_addr,
  input  logic [WIDTH-1:0]         b_wdata,
  output logic [WIDTH-1:0]         b_rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Ports A and B: write, or read into the output register
  always_ff @(posedge clk) begin
    if (a_en) begin
      if (a_we) begin
        mem[a_addr] <= a_wdata;
      end else begin
        a_rdata <= mem[a_addr];
      end
    end
    if (b_en) begin
      if (b_we) begin
        mem[b_addr] <= b_wdata;
      end else begin
        b_rdata <= mem[b_addr];
      end
    end
  end

endmodule

[rtl/active_inactive_set_tracker_core.sv]
// Top level of the active/inactive set tracker: list and map RAMs plus sequencer.
//
// Requests arrive on the in_ channel (in_func: 0 activate, 1 deactivate; in_item_index).
// Each accepted item gives exactly one result on the out_ channel: out_status,
// out_act_count, out_new_position and out_moved_item.
// Both lists share one list RAM: active slot s sits at address s, inactive slot s at
// address ENTRIES-1-s, so both list tails meet at the boundary given by the active count.
// A second RAM maps each item to its active flag and physical address.
// An item is handled in order: a read of the item's map entry and the list tail, then a
// check of the request and a write of both lists and both map entries on both RAM ports.
// No new item is accepted until the previous one leaves its check and loads the result.
// After reset the block sweeps both RAMs, one entry a cycle, over all ENTRIES addresses
// to set every item inactive in identity order; in_ready stays low during that sweep.
// The result sits in an output register, so a new item is accepted while it waits.
// When out_ready is low with a result pending, the next item holds in its check cycle
// until the output register frees up.
module active_inactive_set_tracker_core #(
  parameter int ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [aist_pkg::ITEM_W-1:0] in_item_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_status,
  output logic [aist_pkg::CNT_W-1:0]  out_act_count,
  output logic [aist_pkg::ITEM_W-1:0] out_new_position,
  output logic [aist_pkg::ITEM_W-1:0] out_moved_item
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IXW = (AW > aist_pkg::ITEM_W) ? AW : aist_pkg::ITEM_W;
  localparam int OCW = (CW > aist_pkg::CNT_W) ? CW : aist_pkg::CNT_W;
  localparam int MW  = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic [aist_pkg::ST_W-1:0] state_r, state_nxt;
  logic [AW-1:0] init_cnt_r, init_cnt_nxt;
  logic [CW-1:0] act_cnt_r, act_cnt_nxt;

  // request held across the check cycle
  logic          func_r;
  logic          bad_r;
  logic [AW-1:0] item_r;
  logic [AW-1:0] tail_r;

  logic          out_valid_r;
  logic          out_status_r;
  logic [aist_pkg::CNT_W-1:0]  out_count_r;
  logic [aist_pkg::ITEM_W-1:0] out_pos_r;
  logic [aist_pkg::ITEM_W-1:0] out_moved_r;

  // RAM ports
  logic          la_en, la_we, lb_en, lb_we;
  logic [AW-1:0] la_addr, lb_addr, la_wdata, lb_wdata, la_rdata, lb_rdata;
  logic          ma_en, ma_we, mb_en, mb_we;
  logic [AW-1:0] ma_addr, mb_addr;
  logic [MW-1:0] ma_wdata, mb_wdata, ma_rdata, mb_rdata;

  logic          in_acc;
  logic [IXW-1:0] item_ext;
  logic [AW-1:0] item_addr;
  logic [CW-1:0] tail_ext;
  logic          item_bad;
  logic          flag;
  logic [AW-1:0] hole;
  logic [AW-1:0] tail_item;
  logic          refuse;
  logic          exec_go;
  logic          ok_go;
  logic          same_slot;
  logic [AW-1:0] init_mirror;
  logic [AW-1:0] pos_logical;
  logic [IXW-1:0] pos_ext;
  logic [IXW-1:0] moved_ext;
  logic [OCW-1:0] count_ext;

  // decode the incoming item
  assign in_ready  = (state_r == aist_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign item_ext  = IXW'(in_item_index);
  assign item_addr = item_ext[AW-1:0];
  assign item_bad  = (32'(in_item_index) >= ENTRIES);
  assign tail_ext  = in_func ? (act_cnt_r - CW'(1)) : act_cnt_r;

  // check the request against what the RAMs returned
  assign flag      = mb_rdata[AW];
  assign hole      = mb_rdata[AW-1:0];
  assign tail_item = lb_rdata;
  assign refuse    = bad_r || (flag == !func_r);
  assign exec_go   = (state_r == aist_pkg::ST_EXEC) && (!out_valid_r || out_ready);
  assign ok_go     = exec_go && !refuse;
  assign same_slot = (hole == tail_r);
  assign init_mirror = LAST - init_cnt_r;
  assign pos_logical = func_r ? (LAST - tail_r) : tail_r;
  assign pos_ext     = IXW'(pos_logical);
  assign moved_ext   = IXW'(tail_item);
  assign count_ext   = OCW'(act_cnt_nxt);

  // drive the RAM ports: init sweep, read on accept, write back on check
  always_comb begin
    la_en = 1'b0; la_we = 1'b0; la_addr = hole;   la_wdata = tail_item;
    lb_en = 1'b0; lb_we = 1'b0; lb_addr = tail_r; lb_wdata = item_r;
    ma_en = 1'b0; ma_we = 1'b0; ma_addr = tail_item; ma_wdata = {flag, hole};
    mb_en = 1'b0; mb_we = 1'b0; mb_addr = item_r;    mb_wdata = {!func_r, tail_r};
    if (state_r == aist_pkg::ST_INIT) begin
      la_en = 1'b1; la_we = 1'b1; la_addr = init_mirror; la_wdata = init_cnt_r;
      ma_en = 1'b1; ma_we = 1'b1; ma_addr = init_cnt_r;  ma_wdata = {1'b0, init_mirror};
    end else if (in_acc) begin
      lb_en = 1'b1; lb_addr = tail_ext[AW-1:0];
      mb_en = 1'b1; mb_addr = item_addr;
    end else if (ok_go) begin
      // the tail move is dropped when the item itself is the tail
      la_en = !same_slot; la_we = 1'b1;
      ma_en = !same_slot; ma_we = 1'b1;
      lb_en = 1'b1;       lb_we = 1'b1;
      mb_en = 1'b1;       mb_we = 1'b1;
    end
  end

  // next state, sweep counter and active count
  always_comb begin
    state_nxt    = state_r;
    init_cnt_nxt = init_cnt_r;
    act_cnt_nxt  = act_cnt_r;
    unique case (state_r)
      aist_pkg::ST_INIT: begin
        init_cnt_nxt = init_cnt_r + AW'(1);
        if (init_cnt_r == LAST) begin
          state_nxt = aist_pkg::ST_IDLE;
        end
      end
      aist_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = aist_pkg::ST_EXEC;
        end
      end
      aist_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt = aist_pkg::ST_IDLE;
        end
        if (ok_go) begin
          act_cnt_nxt = func_r ? (act_cnt_r - CW'(1)) : (act_cnt_r + CW'(1));
        end
      end
      default: begin
        state_nxt = aist_pkg::ST_INIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aist_pkg::ST_INIT;
      init_cnt_r  <= '0;
      act_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      act_cnt_r  <= act_cnt_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the request for the check cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      bad_r  <= item_bad;
      item_r <= item_addr;
      tail_r <= tail_ext[AW-1:0];
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= refuse;
      out_count_r  <= count_ext[aist_pkg::CNT_W-1:0];
      out_pos_r    <= refuse ? '0 : pos_ext[aist_pkg::ITEM_W-1:0];
      out_moved_r  <= refuse ? '0 : moved_ext[aist_pkg::ITEM_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_act_count    = out_count_r;
  assign out_new_position = out_pos_r;
  assign out_moved_item   = out_moved_r;

  // list RAM: both lists, active from the bottom, inactive from the top
  aist_ram #(
    .WIDTH(AW),
    .DEPTH(ENTRIES)
  ) u_list_ram (
    .clk    (clk),
    .a_en   (la_en),
    .a_we   (la_we),
    .a_addr (la_addr),
    .a_wdata(la_wdata),
    .a_rdata(la_rdata),
    .b_en   (lb_en),
    .b_we   (lb_we),
    .b_addr (lb_addr),
    .b_wdata(lb_wdata),
    .b_rdata(lb_rdata)
  );

  // map RAM: per item, active flag and physical list address
  aist_ram #(
    .WIDTH(MW),
    .DEPTH(ENTRIES)
  ) u_map_ram (
    .clk    (clk),
    .a_en   (ma_en),
    .a_we   (ma_we),
    .a_addr (ma_addr),
    .a_wdata(ma_wdata),
    .a_rdata(ma_rdata),
    .b_en   (mb_en),
    .b_we   (mb_we),
    .b_addr (mb_addr),
    .b_wdata(mb_wdata),
    .b_rdata(mb_rdata)
  );

endmodule
